// ===== sv/kslm_pkg.sv =====
// ----------------------------------------------------------------------------
// kslm_pkg: shared types and constants of the keepalive strip link monitor
// Item kinds, configuration register indexes, sequencer states, health codes
// and register reset values.
// ----------------------------------------------------------------------------
package kslm_pkg;

  // Kind of one inbound item
  typedef enum logic [2:0] {
    KIND_RX    = 3'd0,
    KIND_TICK  = 3'd1,
    KIND_SENT  = 3'd2,
    KIND_START = 3'd3,
    KIND_STOP  = 3'd4
  } kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAGIC  = 2'd0,
    CFG_PERIOD = 2'd1,
    CFG_STALL  = 2'd2,
    CFG_LOST   = 2'd3
  } cfg_idx_e;

  // Link health codes
  typedef enum logic [1:0] {
    HEALTH_OK      = 2'd0,
    HEALTH_STALLED = 2'd1,
    HEALTH_LOST    = 2'd2
  } health_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RETEST,
    ST_FLUSH,
    ST_TAIL
  } state_e;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned ThreshW   = 16;
  localparam int unsigned MagicIdxW = 3;

  localparam logic [63:0]        MagicReset  = 64'hF15C_E319_A702_4C4D;
  localparam logic [ThreshW-1:0] PeriodReset = 16'd500;
  localparam logic [ThreshW-1:0] StallReset  = 16'd2500;
  localparam logic [ThreshW-1:0] LostReset   = 16'd20000;

endpackage

// ===== sv/keepalive_strip_link_monitor.sv =====
// ----------------------------------------------------------------------------
// keepalive_strip_link_monitor: keepalive magic stripper and link monitor
// Strips the keepalive magic from inbound bytes in a session, ages silence
// and quiet timers on millisecond ticks and reports link health.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  in       | in_valid_i / in_stall_o   | kind_i, rx_byte_i, link_connected_i
//  result   | res_valid_o / res_stall_i | out_byte_o, out_valid_o, last_o,
//           |                           | send_keepalive_o, health_o
//  config   | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
//  An item passes EXEC and TAIL; a mismatch that flushes held bytes adds
//  RETEST and FLUSH (up to MAGIC_LEN results), and TAIL only if the byte is
//  not held again. The sequencer runs one byte compare and one result per
//  cycle while no result stalls. in_stall_o is high while an item is in the
//  sequencer. A stalled result holds the sequencer; a finished result may
//  wait in the output register while the next item is taken. Reset restores
//  register defaults and clears all session state.
module keepalive_strip_link_monitor #(
  parameter int unsigned MAGIC_LEN  = 8,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // inbound items
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       kind_i,
  input  logic [7:0]                       rx_byte_i,
  input  logic                             link_connected_i,
  // results
  output logic                             res_valid_o,
  input  logic                             res_stall_i,
  output logic [7:0]                       out_byte_o,
  output logic                             out_valid_o,
  output logic                             last_o,
  output logic                             send_keepalive_o,
  output logic [1:0]                       health_o,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [kslm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [kslm_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned HW = (MAGIC_LEN > 2) ? $clog2(MAGIC_LEN) : 1;
  localparam int unsigned CW = (TIMER_BITS > kslm_pkg::ThreshW) ? TIMER_BITS
                                                                : kslm_pkg::ThreshW;
  localparam logic [HW-1:0] HoldLast = HW'(MAGIC_LEN - 1);

  // Saturating increment
  function automatic logic [TIMER_BITS-1:0] age(input logic [TIMER_BITS-1:0] v);
    logic [TIMER_BITS-1:0] r;
    r = (&v) ? v : v + TIMER_BITS'(1);
    return r;
  endfunction

  kslm_pkg::state_e state_q, state_d;

  logic [7:0][7:0]                  magic_q;
  logic [kslm_pkg::ThreshW-1:0]     period_q, stall_q, lost_q;

  logic [2:0]                       kind_q;
  logic [7:0]                       byte_q;
  logic                             conn_q;
  logic                             session_q, session_d;
  logic [HW-1:0]                    hold_q, hold_d;
  logic [HW-1:0]                    cnt_q, cnt_d;
  logic [HW-1:0]                    fl_q, fl_d;
  logic                             tail_valid_q, tail_valid_d;
  logic                             ka_q, ka_d;
  logic [TIMER_BITS-1:0]            silent_q, silent_d;
  logic [TIMER_BITS-1:0]            quiet_q, quiet_d;

  logic                             res_valid_q, res_valid_d;
  logic [7:0]                       obyte_q, obyte_d;
  logic                             ovalid_q, ovalid_d;
  logic                             last_q, last_d;
  logic                             oka_q, oka_d;
  logic [1:0]                       health_q, health_d;

  logic                             in_acc;
  logic                             slot;
  logic [kslm_pkg::MagicIdxW-1:0]   mag_idx;
  logic [7:0]                       mag_byte;
  logic                             hit;
  logic [TIMER_BITS-1:0]            quiet_aged;
  logic [CW-1:0]                    silent_x;
  logic [1:0]                       health_c;
  logic                             fl_end;

  assign in_acc = in_valid_i && (state_q == kslm_pkg::ST_IDLE);
  assign slot   = !res_valid_q || !res_stall_i;
  assign fl_end = (cnt_q == fl_q - HW'(1));

  // Shared magic byte select and compare unit
  always_comb begin
    case (state_q)
      kslm_pkg::ST_FLUSH:  mag_idx = kslm_pkg::MagicIdxW'(cnt_q);
      kslm_pkg::ST_RETEST: mag_idx = '0;
      default:             mag_idx = kslm_pkg::MagicIdxW'(hold_q);
    endcase
  end
  assign mag_byte = magic_q[mag_idx];
  assign hit      = (byte_q == mag_byte);

  assign quiet_aged = age(quiet_q);

  // Health from the state after this item's update
  assign silent_x = CW'(silent_q);
  always_comb begin
    if (!session_q) begin
      health_c = kslm_pkg::HEALTH_OK;
    end else if (!conn_q || silent_x >= CW'(lost_q)) begin
      health_c = kslm_pkg::HEALTH_LOST;
    end else if (silent_x >= CW'(stall_q)) begin
      health_c = kslm_pkg::HEALTH_STALLED;
    end else begin
      health_c = kslm_pkg::HEALTH_OK;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kslm_pkg::ST_IDLE: begin
        if (in_acc) state_d = kslm_pkg::ST_EXEC;
      end
      kslm_pkg::ST_EXEC: begin
        if (kind_q == kslm_pkg::KIND_RX && session_q && !hit && hold_q != '0) begin
          state_d = kslm_pkg::ST_RETEST;
        end else begin
          state_d = kslm_pkg::ST_TAIL;
        end
      end
      kslm_pkg::ST_RETEST: state_d = kslm_pkg::ST_FLUSH;
      kslm_pkg::ST_FLUSH: begin
        if (slot && fl_end) begin
          state_d = tail_valid_q ? kslm_pkg::ST_TAIL : kslm_pkg::ST_IDLE;
        end
      end
      kslm_pkg::ST_TAIL: begin
        if (slot) state_d = kslm_pkg::ST_IDLE;
      end
      default: state_d = kslm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result outputs
  always_comb begin
    session_d    = session_q;
    hold_d       = hold_q;
    cnt_d        = cnt_q;
    fl_d         = fl_q;
    tail_valid_d = tail_valid_q;
    ka_d         = ka_q;
    silent_d     = silent_q;
    quiet_d      = quiet_q;
    res_valid_d  = res_valid_q && res_stall_i;
    obyte_d      = obyte_q;
    ovalid_d     = ovalid_q;
    last_d       = last_q;
    oka_d        = oka_q;
    health_d     = health_q;

    case (state_q)
      kslm_pkg::ST_EXEC: begin
        tail_valid_d = 1'b0;
        ka_d         = 1'b0;
        case (kind_q)
          kslm_pkg::KIND_RX: begin
            if (!session_q) begin
              tail_valid_d = 1'b1;
            end else begin
              silent_d = '0;
              if (hit) begin
                hold_d = (hold_q == HoldLast) ? '0 : hold_q + HW'(1);
              end else if (hold_q != '0) begin
                fl_d   = hold_q;
                hold_d = '0;
              end else begin
                tail_valid_d = 1'b1;
              end
            end
          end
          kslm_pkg::KIND_TICK: begin
            silent_d = age(silent_q);
            quiet_d  = quiet_aged;
            if (session_q && conn_q &&
                CW'(quiet_aged) >= CW'(period_q)) begin
              ka_d    = 1'b1;
              quiet_d = '0;
            end
          end
          kslm_pkg::KIND_SENT: quiet_d = '0;
          kslm_pkg::KIND_START: begin
            session_d = 1'b1;
            hold_d    = '0;
            silent_d  = '0;
            quiet_d   = '0;
          end
          kslm_pkg::KIND_STOP: begin
            session_d = 1'b0;
            hold_d    = '0;
          end
          default: ;
        endcase
      end
      kslm_pkg::ST_RETEST: begin
        // retest the byte against the first magic byte
        hold_d       = hit ? HW'(1) : '0;
        tail_valid_d = !hit;
        cnt_d        = '0;
      end
      kslm_pkg::ST_FLUSH: begin
        if (slot) begin
          res_valid_d = 1'b1;
          obyte_d     = mag_byte;
          ovalid_d    = 1'b1;
          last_d      = fl_end && !tail_valid_q;
          oka_d       = 1'b0;
          health_d    = health_c;
          cnt_d       = cnt_q + HW'(1);
        end
      end
      kslm_pkg::ST_TAIL: begin
        if (slot) begin
          res_valid_d = 1'b1;
          obyte_d     = tail_valid_q ? byte_q : 8'h00;
          ovalid_d    = tail_valid_q;
          last_d      = 1'b1;
          oka_d       = ka_q;
          health_d    = health_c;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kslm_pkg::ST_IDLE;
      session_q   <= 1'b0;
      hold_q      <= '0;
      silent_q    <= '0;
      quiet_q     <= '0;
      res_valid_q <= 1'b0;
      magic_q     <= kslm_pkg::MagicReset;
      period_q    <= kslm_pkg::PeriodReset;
      stall_q     <= kslm_pkg::StallReset;
      lost_q      <= kslm_pkg::LostReset;
    end else begin
      state_q     <= state_d;
      session_q   <= session_d;
      hold_q      <= hold_d;
      silent_q    <= silent_d;
      quiet_q     <= quiet_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kslm_pkg::CFG_MAGIC:  magic_q  <= cfg_data_i;
          kslm_pkg::CFG_PERIOD: period_q <= cfg_data_i[kslm_pkg::ThreshW-1:0];
          kslm_pkg::CFG_STALL:  stall_q  <= cfg_data_i[kslm_pkg::ThreshW-1:0];
          kslm_pkg::CFG_LOST:   lost_q   <= cfg_data_i[kslm_pkg::ThreshW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      byte_q <= rx_byte_i;
      conn_q <= link_connected_i;
    end
    cnt_q        <= cnt_d;
    fl_q         <= fl_d;
    tail_valid_q <= tail_valid_d;
    ka_q         <= ka_d;
    obyte_q      <= obyte_d;
    ovalid_q     <= ovalid_d;
    last_q       <= last_d;
    oka_q        <= oka_d;
    health_q     <= health_d;
  end

  assign in_stall_o       = (state_q != kslm_pkg::ST_IDLE);
  assign res_valid_o      = res_valid_q;
  assign out_byte_o       = obyte_q;
  assign out_valid_o      = ovalid_q;
  assign last_o           = last_q;
  assign send_keepalive_o = oka_q;
  assign health_o         = health_q;

  // Holdback never reaches a full magic
  a_hold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(hold_q) < MAGIC_LEN)
    else $error("holdback count out of range");

  // A keepalive request rides only on the single data-free result of a tick
  a_ka_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && oka_q |-> last_q && !ovalid_q && obyte_q == 8'h00)
    else $error("keepalive request on a data result");

  // A result waiting while the sequencer is idle closes its item
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kslm_pkg::ST_IDLE && res_valid_q |-> last_q)
    else $error("item left unfinished");

  // A tail result given while no session is up reads health ok
  a_health_nosess: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kslm_pkg::ST_TAIL && slot && !session_q
    |=> health_q == kslm_pkg::HEALTH_OK)
    else $error("health without session");

  // A flush always follows a retest of a mismatched byte
  a_flush_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == kslm_pkg::ST_FLUSH) |-> $past(state_q) == kslm_pkg::ST_RETEST
    && fl_q != '0)
    else $error("flush without retest");

endmodule
